@@ design/u8dec_pkg.sv @@
// types and constants shared by the utf-8 decoder modules
package u8dec_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_LIMIT     = 3'd4,
    ST_DISABLED  = 3'd5
  } u8dec_status_e;

  // register addresses (byte offsets)
  localparam int unsigned AddrW     = 3;
  localparam logic [AddrW-1:0] RegEnable = 3'h0;
  localparam logic [AddrW-1:0] RegMaxOut = 3'h4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } u8dec_in_t;

  typedef struct packed {
    logic [CpW-1:0]     code_point;
    logic               is_char;
    logic               done_res;
    logic [CountW-1:0]  char_count;
    logic [StatusW-1:0] status;
  } u8dec_out_t;

  // one queue entry: everything one input byte produces
  typedef struct packed {
    logic               has_char;
    logic [CpW-1:0]     code_point;
    logic               has_done;
    logic [CountW-1:0]  char_count;
    logic [StatusW-1:0] status;
  } u8dec_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u8dec_qstat_t;

endpackage

@@ design/utf8_to_codepoint_decoder.sv @@
// top level of the utf-8 to code point decoder with its register port
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------
//  in       | in        | in_valid_i / in_stall_o    | u8dec_in_t
//  out      | out       | out_valid_o / out_stall_i  | u8dec_out_t
//  config   | in        | apb psel/penable/pready    | 32-bit register data
//
// one input byte is taken per cycle while the entry queue has room
// a byte that yields both a code point and a done result gives two output words
// the back end's single output register gives one word per cycle while not stalled
// reset clears the decode state, the queue and the output valid flag; registers
// come up enabled with max_output at 65535
// a stalled output fills the queue, after which in_stall_o rises
module utf8_to_codepoint_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  u8dec_pkg::u8dec_in_t           in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output u8dec_pkg::u8dec_out_t          out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [u8dec_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import u8dec_pkg::*;

  logic         enable_q;
  logic [15:0]  max_out_q;
  logic         wr_en;
  logic         accept;
  logic         push;
  logic         pop;
  u8dec_entry_t entry;
  u8dec_entry_t head;
  u8dec_qstat_t qstat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      max_out_q <= 16'hFFFF;
    end else if (wr_en) begin
      if (paddr[2] == RegMaxOut[2]) begin
        max_out_q <= pwdata[15:0];
      end else begin
        enable_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegMaxOut[2]) begin
      prdata = {16'd0, max_out_q};
    end else begin
      prdata = {31'd0, enable_q};
    end
  end

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  u8dec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (in_data_i),
    .accept_i      (accept),
    .utf8_enable_i (enable_q),
    .max_output_i  (max_out_q),
    .push_o        (push),
    .entry_o       (entry)
  );

  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ design/u8dec_front.sv @@
// front end: takes bytes, runs the decode state and builds queue entries
module u8dec_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  u8dec_pkg::u8dec_in_t      in_data_i,
  input  logic                      accept_i,
  input  logic                      utf8_enable_i,
  input  logic [15:0]               max_output_i,
  output logic                      push_o,
  output u8dec_pkg::u8dec_entry_t   entry_o
);
  import u8dec_pkg::*;

  logic [1:0]         pend_q, pend_d;
  logic [CpW-1:0]     acc_q, acc_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               halt_q, halt_d;
  logic [StatusW-1:0] stst_q, stst_d;

  logic [7:0]         b;
  logic [CountW-1:0]  limit;
  logic               has_char;
  logic [CpW-1:0]     cp;
  logic               has_done;
  logic [StatusW-1:0] done_st;

  assign b     = in_data_i.in_byte;
  assign limit = (max_output_i == '0) ? '0 : max_output_i - 16'd1;

  always_comb begin
    pend_d   = pend_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    halt_d   = halt_q;
    stst_d   = stst_q;
    has_char = 1'b0;
    cp       = '0;
    has_done = 1'b0;
    done_st  = ST_OK;

    if (!utf8_enable_i) begin
      if (in_data_i.last_byte) begin
        has_done = 1'b1;
        done_st  = ST_DISABLED;
      end
    end else begin
      if (halt_q) begin
        if (stst_q == ST_BAD_CONT && pend_q != 2'd0) begin
          pend_d = pend_q - 2'd1;
        end
      end else if (pend_q == 2'd0) begin
        priority if (cnt_q >= limit) begin
          halt_d = 1'b1;
          stst_d = ST_LIMIT;
        end else if (b[7] == 1'b0) begin
          has_char = 1'b1;
          cp       = {13'd0, b};
          cnt_d    = cnt_q + 16'd1;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {16'd0, b[4:0]};
          pend_d = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {17'd0, b[3:0]};
          pend_d = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {18'd0, b[2:0]};
          pend_d = 2'd3;
        end else begin
          halt_d = 1'b1;
          stst_d = ST_BAD_LEAD;
        end
      end else begin
        pend_d = pend_q - 2'd1;
        if (b[7:6] != 2'b10) begin
          halt_d = 1'b1;
          stst_d = ST_BAD_CONT;
        end else begin
          acc_d = {acc_q[CpW-7:0], b[5:0]};
          if (pend_q == 2'd1) begin
            has_char = 1'b1;
            cp       = acc_d;
            cnt_d    = cnt_q + 16'd1;
            acc_d    = '0;
          end
        end
      end
      if (in_data_i.last_byte) begin
        has_done = 1'b1;
        if (pend_d != 2'd0) begin
          done_st = ST_TRUNCATED;
        end else if (halt_d) begin
          done_st = stst_d;
        end else begin
          done_st = ST_OK;
        end
      end
    end

    entry_o.has_char   = has_char;
    entry_o.code_point = cp;
    entry_o.has_done   = has_done;
    // a disabled string end always reports zero characters
    entry_o.char_count = (has_done && utf8_enable_i) ? cnt_d : '0;
    entry_o.status     = done_st;

    // end of string starts a fresh run
    if (in_data_i.last_byte) begin
      pend_d = '0;
      acc_d  = '0;
      cnt_d  = '0;
      halt_d = 1'b0;
      stst_d = ST_OK;
    end
  end

  assign push_o = accept_i && (has_char || has_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      halt_q <= 1'b0;
      stst_q <= ST_OK;
    end else if (accept_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
      stst_q <= stst_d;
    end
  end

  // a string end always leaves a clean run behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_data_i.last_byte |=> pend_q == '0 && cnt_q == '0 && !halt_q)
    else $error("decode state not cleared after last byte");

  // while disabled, inner bytes leave the decode state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !utf8_enable_i && !in_data_i.last_byte |=>
      $stable(pend_q) && $stable(acc_q) && $stable(cnt_q))
    else $error("decode state changed while disabled");

  // a pushed entry always carries something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept_i && (entry_o.has_char || entry_o.has_done))
    else $error("empty entry pushed");

endmodule

@@ design/u8dec_queue.sv @@
// short queue of decoded entries between front and back
module u8dec_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  u8dec_pkg::u8dec_entry_t  push_data_i,
  input  logic                     pop_i,
  output u8dec_pkg::u8dec_entry_t  head_o,
  output u8dec_pkg::u8dec_qstat_t  stat_o
);
  import u8dec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u8dec_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full && !pop_i) && !(pop_i && stat_o.empty))
    else $error("queue pushed while full or popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow push");

endmodule

@@ design/u8dec_back.sv @@
// back end: splits queue entries into result words behind an output register
module u8dec_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  u8dec_pkg::u8dec_entry_t  head_i,
  input  u8dec_pkg::u8dec_qstat_t  qstat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output u8dec_pkg::u8dec_out_t    out_data_o
);
  import u8dec_pkg::*;

  logic       out_valid_q, out_valid_d;
  u8dec_out_t out_data_q, out_data_d;
  logic       char_sent_q, char_sent_d;
  logic       load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    char_sent_d = char_sent_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !qstat_i.empty;
      if (!qstat_i.empty) begin
        if (head_i.has_char && !char_sent_q) begin
          out_data_d.code_point = head_i.code_point;
          out_data_d.is_char    = 1'b1;
          out_data_d.done_res   = 1'b0;
          out_data_d.char_count = '0;
          out_data_d.status     = ST_OK;
          // a char followed by its string end: hold the entry one more word
          if (head_i.has_done) begin
            char_sent_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_data_d.code_point = '0;
          out_data_d.is_char    = 1'b0;
          out_data_d.done_res   = 1'b1;
          out_data_d.char_count = head_i.char_count;
          out_data_d.status     = head_i.status;
          char_sent_d           = 1'b0;
          pop_o                 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      char_sent_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      char_sent_q <= char_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_char && out_data_o.done_res))
    else $error("result word is both char and done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_sent_q |-> !qstat_i.empty && head_i.has_done)
    else $error("split entry lost its done part");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load && !qstat_i.empty)
    else $error("pop without a free output register");

endmodule

@@ bench/utf8_to_codepoint_decoder_chk.sv @@
// checker for the utf-8 decoder: tracks register writes, predicts result words and compares
module utf8_to_codepoint_decoder_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  u8dec_pkg::u8dec_in_t        in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  u8dec_pkg::u8dec_out_t       out_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [u8dec_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output int                          err_cnt_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8dec_pkg::*;

  localparam int MaxReports = 40;

  logic              utf8_en;
  logic [15:0]       max_chars;
  logic [1:0]        cont_left;
  logic [CpW-1:0]    cp_acc;
  logic [CountW-1:0] char_cnt;
  logic              stopped;
  u8dec_status_e     stop_code;
  u8dec_out_t        due_words_q[$];
  int                errs;

  function automatic void restart_string();
    cont_left = '0;
    cp_acc    = '0;
    char_cnt  = '0;
    stopped   = 1'b0;
    stop_code = ST_OK;
  endfunction

  function automatic void halt_on(u8dec_status_e st);
    stopped   = 1'b1;
    stop_code = st;
  endfunction

  function automatic void queue_word(logic [CpW-1:0] cp, logic ch, logic dn,
                                     logic [CountW-1:0] cnt, u8dec_status_e st);
    u8dec_out_t w;
    w.code_point = cp;
    w.is_char    = ch;
    w.done_res   = dn;
    w.char_count = cnt;
    w.status     = st;
    due_words_q.push_back(w);
  endfunction

  function automatic void decode_byte(u8dec_in_t w);
    logic [7:0]        b;
    logic [CountW-1:0] lim;
    u8dec_status_e     st;
    b   = w.in_byte;
    lim = (max_chars == 16'd0) ? '0 : max_chars - 16'd1;
    if (!utf8_en) begin
      // disabled: state is kept until the string ends
      if (w.last_byte) begin
        queue_word('0, 1'b0, 1'b1, '0, ST_DISABLED);
        restart_string();
      end
    end else begin
      if (stopped) begin
        // a bad continuation still uses up the rest of its sequence
        if (stop_code == ST_BAD_CONT && cont_left != 2'd0) cont_left--;
      end else if (cont_left == 2'd0) begin
        if (char_cnt >= lim) begin
          halt_on(ST_LIMIT);
        end else if (!b[7]) begin
          queue_word(CpW'(b), 1'b1, 1'b0, '0, ST_OK);
          char_cnt++;
        end else if (b[7:5] == 3'b110) begin
          cp_acc    = CpW'(b[4:0]);
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc    = CpW'(b[3:0]);
          cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          cp_acc    = CpW'(b[2:0]);
          cont_left = 2'd3;
        end else begin
          halt_on(ST_BAD_LEAD);
        end
      end else begin
        cont_left--;
        if (b[7:6] != 2'b10) begin
          halt_on(ST_BAD_CONT);
        end else begin
          cp_acc = {cp_acc[CpW-7:0], b[5:0]};
          if (cont_left == 2'd0) begin
            queue_word(cp_acc, 1'b1, 1'b0, '0, ST_OK);
            char_cnt++;
            cp_acc = '0;
          end
        end
      end
      if (w.last_byte) begin
        // a cut-off sequence wins over any earlier stop
        if (cont_left != 2'd0) st = ST_TRUNCATED;
        else if (stopped)      st = stop_code;
        else                   st = ST_OK;
        queue_word('0, 1'b0, 1'b1, char_cnt, st);
        restart_string();
      end
    end
  endfunction

  function automatic void cmp_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= MaxReports)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
    end
  endfunction

  function automatic void check_word(u8dec_out_t act);
    u8dec_out_t exp_w;
    if (due_words_q.size() == 0) begin
      errs++;
      if (errs <= MaxReports)
        $display("%0t: unexpected word, expected none actual cp %0h char %0b done %0b %s",
                 $time, act.code_point, act.is_char, act.done_res,
                 $sformatf("cnt %0d st %0d", act.char_count, act.status));
    end else begin
      exp_w = due_words_q.pop_front();
      cmp_field("code_point", 32'(exp_w.code_point), 32'(act.code_point));
      cmp_field("is_char",    32'(exp_w.is_char),    32'(act.is_char));
      cmp_field("done_res",   32'(exp_w.done_res),   32'(act.done_res));
      cmp_field("char_count", 32'(exp_w.char_count), 32'(act.char_count));
      cmp_field("status",     32'(exp_w.status),     32'(act.status));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_en   = 1'b1;
      max_chars = 16'hFFFF;
      restart_string();
      due_words_q.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        unique case (paddr_i)
          RegEnable: utf8_en   = pwdata_i[0];
          RegMaxOut: max_chars = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      err_cnt_o <= errs;
      pending_o <= due_words_q.size();
    end
  end

endmodule

@@ bench/utf8_to_codepoint_decoder_tb.sv @@
// testbench top for the utf-8 decoder: clock, reset, stimulus and verdict
module utf8_to_codepoint_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8dec_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 12;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  u8dec_in_t        in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  u8dec_out_t       out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int         err_cnt;
  int         pending_cnt;
  int         send_idle_pct;
  int         stall_pct;
  int         bytes_sent;
  logic       hold_req;
  logic [7:0] str_q[$];

  always #5 clk_i = ~clk_i;

  utf8_to_codepoint_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  utf8_to_codepoint_decoder_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending_cnt)
  );

  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, last_byte: lst};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[k]) push_byte(str_q[k], k == str_q.size() - 1);
  endtask

  // mostly well-formed strings with random code points, some broken, some noise
  task automatic build_string();
    int          mode;
    int          pos;
    logic [20:0] cp;
    str_q.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 8)) begin
        cp = 21'($urandom);
        case ($urandom_range(0, 3))
          0: str_q.push_back({1'b0, cp[6:0]});
          1: begin
            str_q.push_back({3'b110, cp[10:6]});
            str_q.push_back({2'b10, cp[5:0]});
          end
          2: begin
            str_q.push_back({4'b1110, cp[15:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
          end
          default: begin
            str_q.push_back({5'b11110, cp[20:18]});
            str_q.push_back({2'b10, cp[17:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
          end
        endcase
      end
      if (str_q.size() == 0) str_q.push_back({1'b0, 7'($urandom)});
      if (mode == 1) begin
        pos = $urandom_range(0, str_q.size() - 1);
        str_q[pos] = 8'($urandom);
      end else if (mode == 2 && str_q.size() > 1) begin
        str_q.pop_back();
      end
    end
  endtask

  task automatic run_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_string();
      send_string();
    end
  endtask

  // waits until every predicted word is out, then lets in-flight bytes settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [AddrW-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : rx_side
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("utf8_to_codepoint_decoder_tb: FAIL");
    $finish;
  end

  initial begin : stim
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every sequence length, each stop reason but the limit
    reg_write(RegEnable, 32'd1);
    reg_write(RegMaxOut, 32'd65535);
    str_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
              8'hF0, 8'h90, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string();
    str_q = '{8'h41, 8'h80, 8'h41};
    send_string();
    str_q = '{8'hFF};
    send_string();
    str_q = '{8'hE2, 8'h41, 8'h41, 8'h42};
    send_string();
    str_q = '{8'hF0, 8'h90};
    send_string();
    str_q = '{8'hE2, 8'h00};
    send_string();
    drain();

    // no idling, with one long output hold-off to fill the block
    hold_req <= 1'b1;
    run_random(300);
    drain();

    // limit of zero characters, sender mostly idle
    send_idle_pct = 69;
    reg_write(RegMaxOut, 32'd1);
    str_q = '{8'h41};
    send_string();
    str_q = '{8'hC2, 8'h80};
    send_string();
    drain();
    reg_write(RegMaxOut, 32'd0);
    str_q = '{8'h41, 8'hE2};
    send_string();
    run_random(80);
    drain();

    // two characters allowed, receiver mostly stalling
    send_idle_pct = 0;
    stall_pct     = 69;
    reg_write(RegMaxOut, 32'd3);
    str_q = '{8'h41, 8'h42};
    send_string();
    str_q = '{8'h41, 8'h42, 8'h43};
    send_string();
    run_random(200);
    drain();

    // disabling mid-sequence keeps the partial code point
    stall_pct = 0;
    reg_write(RegMaxOut, 32'd65535);
    push_byte(8'hE2, 1'b0);
    drain();
    reg_write(RegEnable, 32'd0);
    push_byte(8'h41, 1'b0);
    drain();
    reg_write(RegEnable, 32'd1);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b1);
    drain();

    // a character before disabling still gives a disabled end with zero count
    push_byte(8'h41, 1'b0);
    drain();

    // disabled, both sides idling
    send_idle_pct = 35;
    stall_pct     = 35;
    reg_write(RegEnable, 32'd0);
    run_random(200);
    drain();

    reg_write(RegEnable, 32'd1);
    reg_write(RegMaxOut, 32'($urandom_range(2, 20)));
    run_random(250);
    drain();

    send_idle_pct = 69;
    stall_pct     = 0;
    reg_write(RegMaxOut, 32'd65535);
    run_random(200);
    drain();

    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("utf8_to_codepoint_decoder_tb: PASS");
    end else begin
      $display("utf8_to_codepoint_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ utf8_to_codepoint_decoder.f @@
design/u8dec_pkg.sv
design/u8dec_front.sv
design/u8dec_queue.sv
design/u8dec_back.sv
design/utf8_to_codepoint_decoder.sv
bench/utf8_to_codepoint_decoder_chk.sv
bench/utf8_to_codepoint_decoder_tb.sv
